// File: hw/rtl/q8bdp_pkg.sv
// ----------------------------------------------------------------------------
// q8bdp_pkg
// Shared constants, controller states and the command and status structs
// that join the controller to the datapath of the q8 block dot product.
// ----------------------------------------------------------------------------
package q8bdp_pkg;

  // Block geometry: 32 byte pairs, handled 8 lanes at a time.
  localparam int BLOCK_BYTES = 32;
  localparam int LANES       = 8;
  localparam int DOT_STEPS   = BLOCK_BYTES / LANES;
  localparam int STEP_W      = $clog2(DOT_STEPS);
  localparam int BLOCK_W     = BLOCK_BYTES * 8;

  // Integer dot product: magnitude at most 32 * 128 * 128 = 2^19.
  localparam int DOT_W  = 21;
  localparam int MAG_W  = 20;
  // Scale significand product (11 x 11 bits) and block product (20 x 22 bits).
  localparam int SMAN_W = 22;
  localparam int PM_W   = MAG_W + SMAN_W;
  // Alignment field for the fused add, and signed exponent width.
  localparam int FLD_W  = 50;
  localparam int EXP_W  = 11;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOT,
    ST_PROD,
    ST_PNORM,
    ST_ALIGN,
    ST_ADD,
    ST_NORM,
    ST_ROUND
  } state_e;

  typedef struct packed {
    logic              load;
    logic              dot_step;
    logic [STEP_W-1:0] lane;
    logic              prod;
    logic              pnorm;
    logic              align;
    logic              add;
    logic              norm;
    logic              commit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/q8_block_dot_product.sv
// ----------------------------------------------------------------------------
// q8_block_dot_product
// The accumulator is updated at the commit; a last block's sum shows on the
// output at that same edge. No new block pair is taken before the commit:
// the idle state takes the transfer, then come the 4 steps of the 8-lane
// byte multiplier array and the 6-step fp32 fused add sequence. A last block
// waits while the output holds a sum.
// Reset: accumulator cleared to +0, controller idle, output register empty.
// ----------------------------------------------------------------------------
module q8_block_dot_product
  import q8bdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] a_bytes_lo_i,
  input  logic [63:0] a_bytes_mid_lo_i,
  input  logic [63:0] a_bytes_mid_hi_i,
  input  logic [63:0] a_bytes_hi_i,
  input  logic [63:0] b_bytes_lo_i,
  input  logic [63:0] b_bytes_mid_lo_i,
  input  logic [63:0] b_bytes_mid_hi_i,
  input  logic [63:0] b_bytes_hi_i,
  input  logic [15:0] a_scale_half_i,
  input  logic [15:0] b_scale_half_i,
  input  logic        last_block_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] dot_sum_o
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  q8bdp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  q8bdp_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .a_bytes_lo_i     (a_bytes_lo_i),
    .a_bytes_mid_lo_i (a_bytes_mid_lo_i),
    .a_bytes_mid_hi_i (a_bytes_mid_hi_i),
    .a_bytes_hi_i     (a_bytes_hi_i),
    .b_bytes_lo_i     (b_bytes_lo_i),
    .b_bytes_mid_lo_i (b_bytes_mid_lo_i),
    .b_bytes_mid_hi_i (b_bytes_mid_hi_i),
    .b_bytes_hi_i     (b_bytes_hi_i),
    .a_scale_half_i   (a_scale_half_i),
    .b_scale_half_i   (b_scale_half_i),
    .last_block_i     (last_block_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .dot_sum_o        (dot_sum_o)
  );

  // A last block never commits over a sum that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit && status.last |-> status.out_free)
    else $error("last block committed while output register was occupied");

  // An input transfer starts the first lane step of the dot product.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> cmd.dot_step && (cmd.lane == '0))
    else $error("input transfer not followed by first lane step");

  // A new result appears only after a commit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.commit))
    else $error("output valid rose without a commit");

endmodule

// File: hw/rtl/q8bdp_ctrl.sv
// ----------------------------------------------------------------------------
// q8bdp_ctrl
// Controller state machine: walks one block pair through the dot product
// lanes, the scale product, alignment, add, normalization and rounding.
// ----------------------------------------------------------------------------
module q8bdp_ctrl
  import q8bdp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] lane_q, lane_d;

  // State and lane counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lane_q  <= '0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    lane_d     = lane_q;
    cmd_o      = '0;
    cmd_o.lane = lane_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          lane_d     = '0;
          state_d    = ST_DOT;
        end
      end
      ST_DOT: begin
        cmd_o.dot_step = 1'b1;
        lane_d         = lane_q + 1'b1;
        if (lane_q == STEP_W'(DOT_STEPS - 1)) begin
          state_d = ST_PROD;
        end
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = ST_PNORM;
      end
      ST_PNORM: begin
        cmd_o.pnorm = 1'b1;
        state_d     = ST_ALIGN;
      end
      ST_ALIGN: begin
        cmd_o.align = 1'b1;
        state_d     = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_NORM;
      end
      ST_NORM: begin
        cmd_o.norm = 1'b1;
        state_d    = ST_ROUND;
      end
      ST_ROUND: begin
        // A last block needs a free output register to hand off its sum.
        if (!status_i.last || status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/q8bdp_datapath.sv
// ----------------------------------------------------------------------------
// q8bdp_datapath
// Datapath: lane multipliers for the integer dot product, half scale decode,
// block product, fp32 fused add with one rounding, accumulator, output register.
// ----------------------------------------------------------------------------
module q8bdp_datapath
  import q8bdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic [63:0] a_bytes_lo_i,
  input  logic [63:0] a_bytes_mid_lo_i,
  input  logic [63:0] a_bytes_mid_hi_i,
  input  logic [63:0] a_bytes_hi_i,
  input  logic [63:0] b_bytes_lo_i,
  input  logic [63:0] b_bytes_mid_lo_i,
  input  logic [63:0] b_bytes_mid_hi_i,
  input  logic [63:0] b_bytes_hi_i,
  input  logic [15:0] a_scale_half_i,
  input  logic [15:0] b_scale_half_i,
  input  logic        last_block_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] dot_sum_o
);

  // Leading zero count of the product significand.
  function automatic logic [5:0] lzc_pm(input logic [PM_W-1:0] v);
    logic [5:0] n;
    n = 6'(PM_W);
    for (int i = 0; i < PM_W; i++) begin
      if (v[i]) n = 6'(PM_W - 1 - i);
    end
    return n;
  endfunction

  // Leading zero count of the sum.
  function automatic logic [5:0] lzc_sum(input logic [FLD_W:0] v);
    logic [5:0] n;
    n = 6'(FLD_W + 1);
    for (int i = 0; i <= FLD_W; i++) begin
      if (v[i]) n = 6'(FLD_W - i);
    end
    return n;
  endfunction

  // Captured item.
  logic [BLOCK_W-1:0] a_q, b_q;
  logic [15:0]        sa_q, sb_q;
  logic               last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q    <= {a_bytes_hi_i, a_bytes_mid_hi_i, a_bytes_mid_lo_i, a_bytes_lo_i};
      b_q    <= {b_bytes_hi_i, b_bytes_mid_hi_i, b_bytes_mid_lo_i, b_bytes_lo_i};
      sa_q   <= a_scale_half_i;
      sb_q   <= b_scale_half_i;
      last_q <= last_block_i;
    end
  end

  // Eight byte products per step, summed into the running integer dot product.
  logic signed [DOT_W-1:0] part_sum;
  logic signed [DOT_W-1:0] dot_q;

  always_comb begin
    logic signed [15:0] pr;
    part_sum = '0;
    for (int j = 0; j < LANES; j++) begin
      pr = $signed(a_q[(int'(cmd_i.lane) * LANES + j) * 8 +: 8])
         * $signed(b_q[(int'(cmd_i.lane) * LANES + j) * 8 +: 8]);
      part_sum = part_sum + DOT_W'(pr);
    end
  end

  // Half scale decode; the scale product is exact.
  logic [10:0]             ma, mb;
  logic signed [EXP_W-1:0] ea, eb;
  logic                    a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [SMAN_W-1:0]       sman_q;
  logic signed [EXP_W-1:0] sexp_q;
  logic                    snan_q, sinf_q;

  always_comb begin
    ma     = (sa_q[14:10] == 5'd0) ? {1'b0, sa_q[9:0]} : {1'b1, sa_q[9:0]};
    mb     = (sb_q[14:10] == 5'd0) ? {1'b0, sb_q[9:0]} : {1'b1, sb_q[9:0]};
    ea     = (sa_q[14:10] == 5'd0) ? -EXP_W'(24) : $signed(EXP_W'(sa_q[14:10])) - EXP_W'(25);
    eb     = (sb_q[14:10] == 5'd0) ? -EXP_W'(24) : $signed(EXP_W'(sb_q[14:10])) - EXP_W'(25);
    a_nan  = (sa_q[14:10] == 5'h1F) && (sa_q[9:0] != 10'd0);
    b_nan  = (sb_q[14:10] == 5'h1F) && (sb_q[9:0] != 10'd0);
    a_inf  = (sa_q[14:10] == 5'h1F) && (sa_q[9:0] == 10'd0);
    b_inf  = (sb_q[14:10] == 5'h1F) && (sb_q[9:0] == 10'd0);
    a_zero = (sa_q[14:0] == 15'd0);
    b_zero = (sb_q[14:0] == 15'd0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dot_step) begin
      if (cmd_i.lane == '0) begin
        dot_q  <= part_sum;
        sman_q <= ma * mb;
        sexp_q <= ea + eb;
        snan_q <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
        sinf_q <= a_inf || b_inf;
      end else begin
        dot_q <= dot_q + part_sum;
      end
    end
  end

  // Block product: |dot| times the scale significand.
  logic [DOT_W-1:0]        dot_abs;
  logic [PM_W-1:0]         pm_q;
  logic signed [EXP_W-1:0] pe_q;
  logic                    psign_q, pnan_q, pinf_q;

  assign dot_abs = dot_q[DOT_W-1] ? DOT_W'(-dot_q) : DOT_W'(dot_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      pm_q    <= dot_abs[MAG_W-1:0] * sman_q;
      pe_q    <= sexp_q;
      psign_q <= dot_q[DOT_W-1] ^ sa_q[15] ^ sb_q[15];
      pnan_q  <= snan_q || (sinf_q && (dot_q == '0));
      pinf_q  <= sinf_q && !snan_q && (dot_q != '0);
    end
  end

  // Accumulator and operand normalization, special value resolution.
  logic [31:0]             acc_q;
  logic [5:0]              plz;
  logic                    a_zero_acc, a_nan_acc, a_inf_acc, acc_sign;
  logic [PM_W-1:0]         pn_q;
  logic [23:0]             am_q;
  logic signed [EXP_W-1:0] kp_q, ka_q;
  logic                    pz_q, az_q, asign_q;
  logic                    rnan_q, rinf_q, rinf_sign_q;

  always_comb begin
    plz        = lzc_pm(pm_q);
    acc_sign   = acc_q[31];
    a_zero_acc = (acc_q[30:23] == 8'd0);
    a_nan_acc  = (acc_q[30:23] == 8'hFF) && (acc_q[22:0] != 23'd0);
    a_inf_acc  = (acc_q[30:23] == 8'hFF) && (acc_q[22:0] == 23'd0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pnorm) begin
      pn_q        <= pm_q << plz;
      kp_q        <= pe_q + EXP_W'(PM_W - 1) - EXP_W'(plz);
      pz_q        <= (pm_q == '0) && !pinf_q;
      am_q        <= a_zero_acc ? 24'd0 : {1'b1, acc_q[22:0]};
      ka_q        <= $signed(EXP_W'(acc_q[30:23])) - EXP_W'(127);
      az_q        <= a_zero_acc;
      asign_q     <= acc_sign;
      rnan_q      <= pnan_q || a_nan_acc || (pinf_q && a_inf_acc && (psign_q != acc_sign));
      rinf_q      <= pinf_q || a_inf_acc;
      rinf_sign_q <= pinf_q ? psign_q : acc_sign;
    end
  end

  // Alignment: the operand with the lower top exponent shifts right, sticky kept.
  logic                    p_big;
  logic signed [EXP_W-1:0] dexp;
  logic [FLD_W-1:0]        xp, xa, big_v, small_v, small_sh;
  logic [5:0]              sh;
  logic                    full_out, lost;
  logic [FLD_W-1:0]        big_q, small_q;
  logic signed [EXP_W-1:0] k_q;
  logic                    sub_q, bsign_q, zsign_q;

  always_comb begin
    p_big    = !pz_q && (az_q || (kp_q >= ka_q));
    xp       = {pn_q, (FLD_W - PM_W)'(0)};
    xa       = {am_q, (FLD_W - 24)'(0)};
    big_v    = p_big ? xp : xa;
    small_v  = p_big ? xa : xp;
    dexp     = p_big ? (kp_q - ka_q) : (ka_q - kp_q);
    full_out = (dexp < 0) || (dexp >= EXP_W'(FLD_W));
    sh       = dexp[5:0];
    if (full_out) begin
      small_sh = '0;
      lost     = |small_v;
    end else begin
      small_sh = small_v >> sh;
      lost     = |(small_v & ~({FLD_W{1'b1}} << sh));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.align) begin
      big_q   <= big_v;
      small_q <= small_sh | FLD_W'(lost);
      k_q     <= p_big ? kp_q : ka_q;
      sub_q   <= psign_q ^ asign_q;
      bsign_q <= p_big ? psign_q : asign_q;
      zsign_q <= pz_q && az_q && psign_q && asign_q;
    end
  end

  // Signed add of the aligned operands.
  logic [FLD_W+1:0]        sum_raw;
  logic [FLD_W:0]          mag_q;
  logic                    rsign_q;
  logic signed [EXP_W-1:0] k2_q;

  assign sum_raw = sub_q ? ({2'b00, big_q} - {2'b00, small_q})
                         : ({2'b00, big_q} + {2'b00, small_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      mag_q   <= sum_raw[FLD_W+1] ? (FLD_W + 1)'(0) - sum_raw[FLD_W:0] : sum_raw[FLD_W:0];
      rsign_q <= bsign_q ^ sum_raw[FLD_W+1];
      k2_q    <= k_q;
    end
  end

  // Normalize the sum.
  logic [5:0]              slz;
  logic [FLD_W:0]          nm_q;
  logic signed [EXP_W-1:0] emsb_q;
  logic                    mzero_q;

  assign slz = lzc_sum(mag_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.norm) begin
      nm_q    <= mag_q << slz;
      emsb_q  <= k2_q + EXP_W'(1) - EXP_W'(slz);
      mzero_q <= (mag_q == '0);
    end
  end

  // Round to nearest even and assemble the fp32 result.
  logic                    g_bit, st_bit, inc;
  logic [24:0]             rnd;
  logic signed [EXP_W-1:0] e_fin, biased;
  logic [31:0]             res;

  always_comb begin
    g_bit  = nm_q[FLD_W-24];
    st_bit = |nm_q[FLD_W-25:0];
    inc    = g_bit && (st_bit || nm_q[FLD_W-23]);
    rnd    = {1'b0, nm_q[FLD_W:FLD_W-23]} + 25'(inc);
    e_fin  = emsb_q + EXP_W'(rnd[24]);
    biased = e_fin + EXP_W'(127);
    if (rnan_q) begin
      res = QNAN_BITS;
    end else if (rinf_q) begin
      res = {rinf_sign_q, 8'hFF, 23'd0};
    end else if (mzero_q) begin
      res = {zsign_q, 31'd0};
    end else if (biased >= EXP_W'(255)) begin
      res = {rsign_q, 8'hFF, 23'd0};
    end else begin
      res = {rsign_q, biased[7:0], rnd[24] ? 23'd0 : rnd[22:0]};
    end
  end

  // Accumulator: cleared at reset and after a last block.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.commit) begin
      acc_q <= last_q ? 32'd0 : res;
    end
  end

  // Output register: holds the sum until its transfer.
  logic        out_valid_q;
  logic [31:0] dot_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && last_q) begin
      dot_sum_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign dot_sum_o         = dot_sum_q;
  assign status_o.last     = last_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule

// File: bench/q8_block_dot_product_tb.sv
// ----------------------------------------------------------------------------
// q8_block_dot_product_tb
// Self-checking bench for the q8 block dot product. A driver streams block
// pairs from a queue, and a monitor checks every output sum against an exact
// fp32 fused multiply-add predictor kept alongside the stimulus.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module q8_block_dot_product_tb
  import q8bdp_pkg::*;
;

  localparam int NUM_RANDOM  = 2000;
  localparam int TAIL_ITEMS  = 200;
  localparam int IDLE_LIMIT  = 2000;
  localparam int FIX_W       = 300;
  localparam logic [31:0] POS_INF = 32'h7F80_0000;
  localparam logic [31:0] NEG_ZERO = 32'h8000_0000;

  typedef struct packed {
    logic [255:0] a_bytes;
    logic [255:0] b_bytes;
    logic [15:0]  a_scale;
    logic [15:0]  b_scale;
    logic         last;
  } block_pair_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] dot_sum_o;
  block_pair_t drive_pair = '0;

  block_pair_t pending_pairs[$];
  logic [31:0] expected_sums[$];
  logic [31:0] running_sum = 32'd0;

  logic in_fire      = 1'b0;
  int   in_gap       = 0;
  int   out_stall    = 0;
  int   idle_cycles  = 0;
  int   mismatches   = 0;
  int   pairs_sent   = 0;
  int   sums_checked = 0;
  int   special_sums = 0;
  int   num_items;
  bit   tail_phase   = 1'b0;

  q8_block_dot_product i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .a_bytes_lo_i    (drive_pair.a_bytes[63:0]),
    .a_bytes_mid_lo_i(drive_pair.a_bytes[127:64]),
    .a_bytes_mid_hi_i(drive_pair.a_bytes[191:128]),
    .a_bytes_hi_i    (drive_pair.a_bytes[255:192]),
    .b_bytes_lo_i    (drive_pair.b_bytes[63:0]),
    .b_bytes_mid_lo_i(drive_pair.b_bytes[127:64]),
    .b_bytes_mid_hi_i(drive_pair.b_bytes[191:128]),
    .b_bytes_hi_i    (drive_pair.b_bytes[255:192]),
    .a_scale_half_i  (drive_pair.a_scale),
    .b_scale_half_i  (drive_pair.b_scale),
    .last_block_i    (drive_pair.last),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .dot_sum_o       (dot_sum_o)
  );

  // Clock with an 8 ns period.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Exact integer dot product of the 32 signed byte pairs.
  function automatic int byte_dot(logic [255:0] a, logic [255:0] b);
    int acc;
    acc = 0;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      acc += int'(signed'(a[8*i +: 8])) * int'(signed'(b[8*i +: 8]));
    end
    return acc;
  endfunction

  // A finite half as integer significand times a power of two.
  function automatic void half_parts(logic [15:0] h, output longint sig, output int pow2);
    if (h[14:10] == 5'd0) begin
      sig  = h[9:0];
      pow2 = -24;
    end else begin
      sig  = 1024 + h[9:0];
      pow2 = int'(h[14:10]) - 25;
    end
  endfunction

  // Round an exact fixed-point magnitude (LSB 2^-149) to fp32 nearest-even.
  function automatic logic [31:0] round_fp32(logic sign, logic [FIX_W-1:0] mag);
    int          msb;
    int          sh;
    logic [24:0] keep;
    logic        half_bit;
    logic        sticky;
    int          expo;
    msb = 0;
    for (int i = FIX_W - 1; i >= 0; i--) begin
      if (mag[i] && msb == 0) msb = i;
    end
    if (mag < (FIX_W'(1) << 23)) return {sign, 8'd0, mag[22:0]};
    sh       = msb - 23;
    keep     = 25'(mag >> sh);
    half_bit = (sh > 0) ? mag[sh-1] : 1'b0;
    sticky   = (sh > 1) ? ((mag & ((FIX_W'(1) << (sh - 1)) - 1)) != 0) : 1'b0;
    if (half_bit && (sticky || keep[0])) keep = keep + 25'd1;
    expo = sh + 1;
    if (keep[24]) begin
      keep = keep >> 1;
      expo = expo + 1;
    end
    if (expo >= 255) return {sign, POS_INF[30:0]};
    return {sign, 8'(expo), keep[22:0]};
  endfunction

  // One accumulator update: sum = dot * (sa * sb) + sum, rounded once.
  function automatic logic [31:0] fused_update(int dot, logic [15:0] ha, logic [15:0] hb,
                                               logic [31:0] acc);
    logic             a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic             s_nan, s_inf, p_nan, p_inf, p_sign, c_nan, c_inf, c_sign;
    longint           ma, mb, mag;
    int               ea, eb;
    logic [FIX_W-1:0] pm, cm, total;
    a_nan  = ha[14:10] == 5'h1F && ha[9:0] != 0;
    b_nan  = hb[14:10] == 5'h1F && hb[9:0] != 0;
    a_inf  = ha[14:10] == 5'h1F && ha[9:0] == 0;
    b_inf  = hb[14:10] == 5'h1F && hb[9:0] == 0;
    a_zero = ha[14:0] == 0;
    b_zero = hb[14:0] == 0;
    s_nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    s_inf  = !s_nan && (a_inf || b_inf);
    p_nan  = s_nan || (s_inf && dot == 0);
    p_inf  = s_inf && dot != 0;
    p_sign = ha[15] ^ hb[15] ^ (dot < 0);
    c_nan  = acc[30:23] == 8'hFF && acc[22:0] != 0;
    c_inf  = acc[30:23] == 8'hFF && acc[22:0] == 0;
    c_sign = acc[31];
    if (p_nan || c_nan) return QNAN_BITS;
    if (p_inf && c_inf && p_sign != c_sign) return QNAN_BITS;
    if (p_inf) return {p_sign, POS_INF[30:0]};
    if (c_inf) return acc;
    half_parts(ha, ma, ea);
    half_parts(hb, mb, eb);
    mag = longint'(dot < 0 ? -dot : dot) * ma * mb;
    pm  = FIX_W'(mag) << (ea + eb + 149);
    if (acc[30:23] == 0) cm = FIX_W'(acc[22:0]);
    else cm = FIX_W'({1'b1, acc[22:0]}) << (int'(acc[30:23]) - 1);
    total = (p_sign ? -pm : pm) + (c_sign ? -cm : cm);
    if (total == 0) return (p_sign && acc == NEG_ZERO) ? NEG_ZERO : 32'd0;
    if (total[FIX_W-1]) return round_fp32(1'b1, -total);
    return round_fp32(1'b0, total);
  endfunction

  // Fold an accepted block pair into the running sum; a last pair yields a sum.
  task automatic accumulate_pair(block_pair_t p);
    running_sum = fused_update(byte_dot(p.a_bytes, p.b_bytes), p.a_scale, p.b_scale,
                               running_sum);
    if (p.last) begin
      expected_sums.push_back(running_sum);
      running_sum = 32'd0;
    end
  endtask

  function automatic block_pair_t fill_pair(logic [7:0] ab, logic [7:0] bb, logic [15:0] ha,
                                            logic [15:0] hb, logic last);
    block_pair_t p;
    p.a_bytes = {32{ab}};
    p.b_bytes = {32{bb}};
    p.a_scale = ha;
    p.b_scale = hb;
    p.last    = last;
    return p;
  endfunction

  function automatic logic [7:0] pick_byte(bit extreme);
    if (!extreme) return 8'($urandom);
    unique case ($urandom_range(0, 4))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return {1'($urandom), 5'($urandom_range(8, 22)), 10'($urandom)};
    if (r < 84) return {1'($urandom), 5'd0, 10'($urandom)};
    if (r < 88) return {1'($urandom), 15'd0};
    if (r < 90) return {1'($urandom), 5'h1F, 10'd0};
    if (r < 91) return {1'($urandom), 5'h1F, 10'($urandom_range(1, 1023))};
    return 16'($urandom);
  endfunction

  function automatic block_pair_t random_pair();
    block_pair_t p;
    bit          extreme;
    extreme = $urandom_range(0, 3) == 0;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      p.a_bytes[8*i +: 8] = pick_byte(extreme);
      p.b_bytes[8*i +: 8] = pick_byte(extreme);
    end
    p.a_scale = pick_scale();
    p.b_scale = pick_scale();
    p.last    = $urandom_range(0, 4) == 0;
    return p;
  endfunction

  // Input transfers are sampled at the rising edge.
  always @(posedge clk_i) begin
    in_fire <= in_valid_i && in_ready_o;
  end

  // Driver: retire the transferred pair, then present the next one or idle.
  always @(negedge clk_i) begin
    logic next_valid;
    next_valid = in_valid_i;
    if (rst_ni) begin
      if (in_fire) begin
        accumulate_pair(drive_pair);
        pairs_sent++;
        next_valid = 1'b0;
        if (!tail_phase && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 11);
      end
      if (!next_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_pairs.size() > 0) begin
          drive_pair <= pending_pairs.pop_front();
          next_valid = 1'b1;
        end
      end
      tail_phase <= pending_pairs.size() < TAIL_ITEMS;
    end
    in_valid_i <= next_valid;
  end

  // Output back-pressure in random bursts.
  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      if (rst_ni && !tail_phase && $urandom_range(0, 5) == 0) out_stall = $urandom_range(1, 11);
    end
  end

  // Monitor: compare each output transfer with the oldest expected sum.
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected sum transfer: %08h", dot_sum_o);
      end else begin
        want = expected_sums.pop_front();
        sums_checked++;
        if (want[30:23] == 8'hFF) special_sums++;
        if (dot_sum_o !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("dot_sum mismatch: expected %08h, actual %08h", want, dot_sum_o);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles.", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;

    // Directed pairs: byte extremes, scale classes and IEEE special cases.
    pending_pairs.push_back(fill_pair(8'h00, 8'h00, 16'h3C00, 16'h3C00, 1'b1));
    pending_pairs.push_back(fill_pair(8'h80, 8'h80, 16'h3C00, 16'h3C00, 1'b0));
    pending_pairs.push_back(fill_pair(8'h7F, 8'h7F, 16'h3C00, 16'h3C00, 1'b0));
    pending_pairs.push_back(fill_pair(8'h80, 8'h7F, 16'h3C00, 16'h3C00, 1'b1));
    pending_pairs.push_back(fill_pair(8'h01, 8'h01, 16'h0001, 16'h0001, 1'b1));
    pending_pairs.push_back(fill_pair(8'hFF, 8'h01, 16'h03FF, 16'h83FF, 1'b1));
    pending_pairs.push_back(fill_pair(8'h80, 8'h80, 16'h7BFF, 16'h7BFF, 1'b0));
    pending_pairs.push_back(fill_pair(8'h80, 8'h80, 16'hFBFF, 16'h7BFF, 1'b1));
    pending_pairs.push_back(fill_pair(8'h05, 8'hFD, 16'h3555, 16'h4A00, 1'b0));
    pending_pairs.push_back(fill_pair(8'h05, 8'h03, 16'h3555, 16'h4A00, 1'b1));
    pending_pairs.push_back(fill_pair(8'h11, 8'h22, 16'h8000, 16'h3C00, 1'b1));
    pending_pairs.push_back(fill_pair(8'h00, 8'h00, 16'h8000, 16'h8000, 1'b1));
    pending_pairs.push_back(fill_pair(8'h03, 8'h04, 16'h7C00, 16'h3C00, 1'b1));
    pending_pairs.push_back(fill_pair(8'h03, 8'h04, 16'h7C00, 16'h0000, 1'b1));
    pending_pairs.push_back(fill_pair(8'h00, 8'h04, 16'hFC00, 16'h3C00, 1'b1));
    pending_pairs.push_back(fill_pair(8'h03, 8'h04, 16'h7E01, 16'h3C00, 1'b1));
    pending_pairs.push_back(fill_pair(8'h03, 8'h04, 16'h7C00, 16'h3C00, 1'b0));
    pending_pairs.push_back(fill_pair(8'h03, 8'h04, 16'hFC00, 16'h3C00, 1'b1));
    pending_pairs.push_back(fill_pair(8'h7F, 8'h81, 16'h0400, 16'h0001, 1'b0));
    pending_pairs.push_back(fill_pair(8'h01, 8'h01, 16'h7BFF, 16'h3C01, 1'b1));
    for (int i = 0; i < NUM_RANDOM; i++) pending_pairs.push_back(random_pair());
    pending_pairs.push_back(random_pair());
    pending_pairs[$].last = 1'b1;
    num_items = pending_pairs.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every pair has been transferred and folded in, then every sum returned.
    wait (pairs_sent == num_items);
    wait (expected_sums.size() == 0);
    repeat (30) @(posedge clk_i);

    $display("Sent %0d block pairs; checked %0d sums, %0d of them infinite or NaN.",
             pairs_sent, sums_checked, special_sums);
    if (mismatches == 0 && expected_sums.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("Mismatches: %0d, sums still expected: %0d.", mismatches,
               expected_sums.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
